FILE: rtl/core/phase_area_perimeter_stats_assert.svh
// ----------------------------------------------------------------------------
// Phase statistics assertion macros
// Shared property wrappers for the checker of the phase statistics block.
// ----------------------------------------------------------------------------
`ifndef PHASE_AREA_PERIMETER_STATS_ASSERT_SVH
`define PHASE_AREA_PERIMETER_STATS_ASSERT_SVH

// General property, sampled on clk and disabled while arst_n is low
`define PAP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Property that must hold whenever a report transaction is on offer
`define PAP_ASSERT_REPORT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) report_valid |-> (cond)) \
		else $error(msg);

`endif

FILE: rtl/core/pap_pkg.sv
// ----------------------------------------------------------------------------
// Phase statistics package
// Geometry limits, field widths, register codes and shared stage types.
// ----------------------------------------------------------------------------
package pap_pkg;

	// frame and phase limits
	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_HEIGHT   = 4096;
	localparam int NUM_PHASES   = 13;
	localparam int CLINKER_LAST = 6;
	localparam int CLINKER_TOP  = (CLINKER_LAST < NUM_PHASES) ? CLINKER_LAST : NUM_PHASES;

	// widths
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int DIM_W       = 13;
	localparam int LABEL_W     = 4;
	localparam int PHASE_W     = $clog2(NUM_PHASES);
	localparam int PIX_W       = 25;
	localparam int EDGE_W      = 27;
	localparam int ADD_W       = 3;
	localparam int LINE_WORD_W = 2 * LABEL_W;
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [LABEL_W-1:0] label_t;

	// pixel entering the line memory stage
	typedef struct packed {
		logic             valid;
		label_t           label;
		logic [COL_W-1:0] column;
		logic             row_odd;
		logic             interior;
		logic             frame_end;
	} pix_s0_t;

	// write-back into the line memory
	typedef struct packed {
		logic                   en;
		logic [COL_W-1:0]       addr;
		logic [LINE_WORD_W-1:0] data;
	} line_wr_t;

	// counter update produced by the window stage
	typedef struct packed {
		logic             valid;
		label_t           label;
		logic             judge;
		label_t           judge_phase;
		logic [ADD_W-1:0] edge_add;
		logic             frame_end;
	} cnt_upd_t;

endpackage

FILE: rtl/core/pap_line_ram.sv
// ----------------------------------------------------------------------------
// Line memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pap_line_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read, read returns the old word on a same-address collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/pap_window.sv
// ----------------------------------------------------------------------------
// Neighborhood window stage
// Merges the line memory word with the new label, writes it back, shifts the
// 3x3 neighborhood and judges the center pixel against its four neighbors.
// ----------------------------------------------------------------------------
module pap_window import pap_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pix_s0_t                s0,
	input  logic [LINE_WORD_W-1:0] rd_word,
	output line_wr_t               line_wr,
	output cnt_upd_t               upd
);

	logic                   v_s1;
	label_t                 label_s1;
	logic [COL_W-1:0]       col_s1;
	logic                   odd_s1;
	logic                   interior_s1;
	logic                   fe_s1;

	logic                   fwd_q;
	logic [LINE_WORD_W-1:0] fwd_word_q;

	// window: top/mid/bot of the newest column, left is mid of the one before
	label_t                 top_q;
	label_t                 mid_q;
	label_t                 bot_q;
	label_t                 left_q;

	logic [LINE_WORD_W-1:0] word;
	logic [LINE_WORD_W-1:0] wr_word;
	label_t                 up_new;
	label_t                 mid_new;

	// take the word just written when the previous pixel hit the same column
	always_comb begin
		word    = fwd_q ? fwd_word_q : rd_word;
		up_new  = odd_s1 ? word[LINE_WORD_W-1:LABEL_W] : word[LABEL_W-1:0];
		mid_new = odd_s1 ? word[LABEL_W-1:0] : word[LINE_WORD_W-1:LABEL_W];
		wr_word = odd_s1 ? {label_s1, word[LABEL_W-1:0]}
		                 : {word[LINE_WORD_W-1:LABEL_W], label_s1};
	end

	// judge the center pixel: count pore faces among its four neighbors
	always_comb begin
		line_wr.en       = v_s1;
		line_wr.addr     = col_s1;
		line_wr.data     = wr_word;
		upd.valid        = v_s1;
		upd.label        = label_s1;
		upd.judge        = v_s1 && interior_s1 && (mid_q != '0);
		upd.judge_phase  = mid_q;
		upd.edge_add     = ADD_W'(top_q == '0) + ADD_W'(bot_q == '0)
		                 + ADD_W'(left_q == '0) + ADD_W'(mid_new == '0);
		upd.frame_end    = v_s1 && fe_s1;
	end

	// stage control and collision flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			v_s1  <= s0.valid;
			fwd_q <= s0.valid && v_s1 && (s0.column == col_s1);
		end
	end

	// stage payload, forwarded word and window shift
	always_ff @(posedge clk) begin
		if (s0.valid) begin
			label_s1    <= s0.label;
			col_s1      <= s0.column;
			odd_s1      <= s0.row_odd;
			interior_s1 <= s0.interior;
			fe_s1       <= s0.frame_end;
			fwd_word_q  <= wr_word;
		end
		if (v_s1) begin
			left_q <= mid_q;
			mid_q  <= mid_new;
			top_q  <= up_new;
			bot_q  <= label_s1;
		end
	end

endmodule

FILE: rtl/core/pap_stats.sv
// ----------------------------------------------------------------------------
// Phase counters and report
// Per-phase pixel and edge counters, frame snapshot and the report output
// register that drains one phase per transaction.
// ----------------------------------------------------------------------------
module pap_stats import pap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cnt_upd_t           upd,
	output logic               busy,
	input  logic               report_stall,
	output logic               report_valid,
	output logic [LABEL_W-1:0] phase_id,
	output logic [PIX_W-1:0]   pixel_count,
	output logic [EDGE_W-1:0]  edge_count,
	output logic [PIX_W-1:0]   solid_count,
	output logic [PIX_W-1:0]   clinker_count,
	output logic               last_item
);

	logic [PIX_W-1:0]   pix_q      [NUM_PHASES];
	logic [EDGE_W-1:0]  edge_q     [NUM_PHASES];
	logic [PIX_W-1:0]   solid_q;
	logic [PIX_W-1:0]   clink_q;
	logic [PIX_W-1:0]   pix_next   [NUM_PHASES];
	logic [EDGE_W-1:0]  edge_next  [NUM_PHASES];
	logic [PIX_W-1:0]   solid_next;
	logic [PIX_W-1:0]   clink_next;

	logic [PIX_W-1:0]   snap_pix_q  [NUM_PHASES];
	logic [EDGE_W-1:0]  snap_edge_q [NUM_PHASES];
	logic [PIX_W-1:0]   snap_solid_q;
	logic [PIX_W-1:0]   snap_clink_q;

	logic               busy_q;
	logic [PHASE_W-1:0] idx_q;
	logic               load;

	logic               out_valid_q;
	logic [LABEL_W-1:0] phase_id_q;
	logic [PIX_W-1:0]   pix_out_q;
	logic [EDGE_W-1:0]  edge_out_q;
	logic [PIX_W-1:0]   solid_out_q;
	logic [PIX_W-1:0]   clink_out_q;
	logic               last_q;

	// one incrementer per phase lane
	always_comb begin
		for (int k = 0; k < NUM_PHASES; k++) begin
			pix_next[k]  = pix_q[k]
			             + PIX_W'(upd.valid && (upd.label == LABEL_W'(k + 1)));
			edge_next[k] = edge_q[k]
			             + ((upd.judge && (upd.judge_phase == LABEL_W'(k + 1)))
			                ? EDGE_W'(upd.edge_add) : '0);
		end
		solid_next = solid_q + PIX_W'(upd.valid && (upd.label != '0));
		clink_next = clink_q + PIX_W'(upd.valid && (upd.label != '0)
		                              && (upd.label <= LABEL_W'(CLINKER_TOP)));
	end

	// advance the counters, or snapshot and clear them at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PHASES; k++) begin
				pix_q[k]  <= '0;
				edge_q[k] <= '0;
			end
			solid_q <= '0;
			clink_q <= '0;
		end else if (upd.frame_end) begin
			for (int k = 0; k < NUM_PHASES; k++) begin
				pix_q[k]  <= '0;
				edge_q[k] <= '0;
			end
			solid_q <= '0;
			clink_q <= '0;
		end else begin
			for (int k = 0; k < NUM_PHASES; k++) begin
				pix_q[k]  <= pix_next[k];
				edge_q[k] <= edge_next[k];
			end
			solid_q <= solid_next;
			clink_q <= clink_next;
		end
	end

	// hold the finished frame while the report drains
	always_ff @(posedge clk) begin
		if (upd.frame_end) begin
			for (int k = 0; k < NUM_PHASES; k++) begin
				snap_pix_q[k]  <= pix_next[k];
				snap_edge_q[k] <= edge_next[k];
			end
			snap_solid_q <= solid_next;
			snap_clink_q <= clink_next;
		end
	end

	assign load = busy_q && (!out_valid_q || !report_stall);

	// report sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd.frame_end) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				if (idx_q == PHASE_W'(NUM_PHASES - 1)) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!report_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, held while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			phase_id_q  <= LABEL_W'(idx_q) + 1'b1;
			pix_out_q   <= snap_pix_q[idx_q];
			edge_out_q  <= snap_edge_q[idx_q];
			solid_out_q <= snap_solid_q;
			clink_out_q <= snap_clink_q;
			last_q      <= (idx_q == PHASE_W'(NUM_PHASES - 1));
		end
	end

	assign busy          = busy_q;
	assign report_valid  = out_valid_q;
	assign phase_id      = phase_id_q;
	assign pixel_count   = pix_out_q;
	assign edge_count    = edge_out_q;
	assign solid_count   = solid_out_q;
	assign clinker_count = clink_out_q;
	assign last_item     = last_q;

endmodule

FILE: rtl/core/phase_area_perimeter_stats.sv
// ----------------------------------------------------------------------------
// Phase area and perimeter statistics
// Counts pixels and pore-facing edges per phase over a raster label frame
// and reports one transaction per phase after each frame.
//
// Channel   Handshake              Payload
// pixel     pixel_valid/stall      phase_label
// report    report_valid/stall     phase_id, pixel_count, edge_count,
//                                  solid_count, clinker_count, last_item
// cfg       cfg_valid/ready        cfg_index, cfg_data
//
// One pixel per cycle while pixel_stall is low; line memory read at accept, write-back in the next cycle.
// The 13 report transactions go out one per cycle while report_stall is low, behind an output register.
// A frame-closing pixel waits while the previous report is still draining.
// After reset a clearing pass writes MAX_WIDTH (4096) line memory entries,
// one per cycle, with pixel_stall high; cfg writes are taken at any time.
// ----------------------------------------------------------------------------
module phase_area_perimeter_stats import pap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [LABEL_W-1:0]   phase_label,
	output logic                 report_valid,
	input  logic                 report_stall,
	output logic [LABEL_W-1:0]   phase_id,
	output logic [PIX_W-1:0]     pixel_count,
	output logic [EDGE_W-1:0]    edge_count,
	output logic [PIX_W-1:0]     solid_count,
	output logic [PIX_W-1:0]     clinker_count,
	output logic                 last_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t                 state_q;
	logic [COL_W-1:0]       clr_addr_q;

	logic [DIM_W-1:0]       width_q;
	logic [DIM_W-1:0]       height_q;
	logic [DIM_W-1:0]       w_eff;
	logic [DIM_W-1:0]       h_eff;

	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic [DIM_W-1:0]       col_inc;
	logic [DIM_W-1:0]       row_inc;
	logic                   row_end;
	logic                   frame_end_now;

	logic                   clearing;
	logic                   accept;
	label_t                 label_in;
	pix_s0_t                s0;
	line_wr_t               line_wr;
	cnt_upd_t               upd;
	logic                   stats_busy;
	logic [LINE_WORD_W-1:0] rd_word;

	logic                   ram_wr_en;
	logic [COL_W-1:0]       ram_wr_addr;
	logic [LINE_WORD_W-1:0] ram_wr_data;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					width_q <= cfg_data;
				end
				REG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// limit geometry to the supported range
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// raster position and frame end detection
	always_comb begin
		clearing      = (state_q == ST_CLEAR);
		col_inc       = DIM_W'(col_q) + 1'b1;
		row_inc       = DIM_W'(row_q) + 1'b1;
		row_end       = (col_inc >= w_eff);
		frame_end_now = row_end && (row_inc >= h_eff);
		label_in      = (phase_label > LABEL_W'(NUM_PHASES)) ? '0 : phase_label;
	end

	// hold all pixels while clearing, and a frame-closing pixel until the report snapshot is free
	assign pixel_stall = clearing
	                  || (frame_end_now && (stats_busy || upd.frame_end));
	assign accept      = pixel_valid && !pixel_stall;

	always_comb begin
		s0.valid     = accept;
		s0.label     = label_in;
		s0.column    = col_q;
		s0.row_odd   = row_q[0];
		s0.interior  = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
		s0.frame_end = frame_end_now;
	end

	// advance the raster position on each pixel transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end_now ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// clear the line memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_comb begin
		ram_wr_en   = clearing || line_wr.en;
		ram_wr_addr = clearing ? clr_addr_q : line_wr.addr;
		ram_wr_data = clearing ? '0 : line_wr.data;
	end

	pap_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (LINE_WORD_W)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_word),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	pap_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.s0      (s0),
		.rd_word (rd_word),
		.line_wr (line_wr),
		.upd     (upd)
	);

	pap_stats u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd           (upd),
		.busy          (stats_busy),
		.report_stall  (report_stall),
		.report_valid  (report_valid),
		.phase_id      (phase_id),
		.pixel_count   (pixel_count),
		.edge_count    (edge_count),
		.solid_count   (solid_count),
		.clinker_count (clinker_count),
		.last_item     (last_item)
	);

endmodule

FILE: rtl/core/pap_checker.sv
// ----------------------------------------------------------------------------
// Phase statistics port checker
// Watches the report channel of the top level over time.
// ----------------------------------------------------------------------------
`include "phase_area_perimeter_stats_assert.svh"

module pap_checker import pap_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               report_valid,
	input logic               report_stall,
	input logic [LABEL_W-1:0] phase_id,
	input logic [PIX_W-1:0]   pixel_count,
	input logic [EDGE_W-1:0]  edge_count,
	input logic [PIX_W-1:0]   solid_count,
	input logic [PIX_W-1:0]   clinker_count,
	input logic               last_item
);

	// phase is in range and the last transaction is the top phase
	`PAP_ASSERT_REPORT(a_phase_range, (phase_id != '0) && (phase_id <= LABEL_W'(NUM_PHASES)), "phase_id out of range")
	`PAP_ASSERT_REPORT(a_last_phase, last_item == (phase_id == LABEL_W'(NUM_PHASES)), "last_item does not match the final phase")

	// totals bound every per-phase pixel count and the clinker count
	`PAP_ASSERT_REPORT(a_totals, (clinker_count <= solid_count) && (pixel_count <= solid_count), "count exceeds solid total")

	// a report drains without gaps, phases ascending, totals unchanged
	`PAP_ASSERT(a_report_seq, report_valid && !report_stall && !last_item |=> report_valid && (phase_id == $past(phase_id) + 1'b1) && (solid_count == $past(solid_count)) && (clinker_count == $past(clinker_count)), "report sequence broken")

	// a stalled report transaction holds
	`PAP_ASSERT(a_stall_hold, report_valid && report_stall |=> report_valid && $stable(phase_id) && $stable(pixel_count) && $stable(edge_count), "stalled report changed")

endmodule

bind phase_area_perimeter_stats pap_checker u_pap_checker (.*);
